// ----- design/tcw_pkg.sv -----
// Shared constants, types and codes of the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = COLOR_W + CHAR_W;

    // Last cell index that is a copy destination during a scroll.
    localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CODE       = 8'h20;
    localparam logic [COLOR_W-1:0] FILL_COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0]  BLANK_RESET      = {FILL_COLOR_RESET, BLANK_CODE};

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [PADDR_W-3:0] REG_FILL_COLOR = 1'd0;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RWAIT,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_INIT,
        MEM_FILL,
        MEM_COPY,
        MEM_READ
    } t_mem_op;

    typedef enum logic [1:0] {
        CUR_NONE,
        CUR_HOME,
        CUR_ADV,
        CUR_NEWLINE
    } t_cur_op;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clear;
        logic    cnt_inc;
        t_mem_op mem_op;
        t_cur_op cur_op;
        logic    set_scrolled;
        logic    capture;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                is_newline;
        logic                col_last;
        logic                row_last;
        logic                cnt_copy_last;
        logic                cnt_last;
        logic                out_busy;
    } t_dp_sts;

endpackage

// ----- design/tcw_in_if.sv -----
// Input channel of the text console writer: one command per transaction.
interface tcw_in_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  cell_color;
    logic [COL_W-1:0]    read_col;
    logic [ROW_W-1:0]    read_row;

    modport source (
        output valid, action, char_code, cell_color, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, cell_color, read_col, read_row,
        output ready
    );
endinterface

// ----- design/tcw_out_if.sv -----
// Result channel of the text console writer: one result per transaction.
interface tcw_out_if;
    import tcw_pkg::*;

    logic               valid;
    logic               ready;
    logic [CELL_W-1:0]  cell_data;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic               scrolled;

    modport source (
        output valid, cell_data, cursor_row, cursor_col, scrolled,
        input  ready
    );
    modport sink (
        input  valid, cell_data, cursor_row, cursor_col, scrolled,
        output ready
    );
endinterface

// ----- design/text_console_writer_top.sv -----
// Top level of the text console writer: channels, configuration register, controller, datapath.
// A put or newline without scroll runs through the controller states S_EXEC and S_DONE; a read
// adds S_RWAIT, a clear sweeps in S_CLEAR, and a scroll adds S_SCROLL, S_DRAIN and S_FILL.
// A command is taken only in S_IDLE, after the last one has been loaded into the result register;
// the single-write, single-read screen store is swept one cell a cycle by clear and scroll.
// Reset (synchronous, active low) homes the cursor, sets fill_color to 7 and then writes
// every cell to 0x0720, all COLUMNS*ROWS (2000) cells, during which no command is taken.
module text_console_writer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tcw_in_if.sink                            i_cmd,
    tcw_out_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]       paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tcw_pkg::*;

    // Configuration: the fill color lives in word 0 of the register space. Writes land
    // in the access phase; writes to any other word are dropped and read back as zero.
    logic [COLOR_W-1:0] r_fill_color;
    logic               n_fill_color_we;
    logic               reg_hit;

    assign reg_hit         = (paddr[PADDR_W-1:2] == REG_FILL_COLOR);
    assign n_fill_color_we = psel && penable && pwrite && reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= FILL_COLOR_RESET;
        end else if (n_fill_color_we) begin
            r_fill_color <= pwdata[COLOR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? APB_DATA_W'(r_fill_color) : '0;

    // The controller decides what happens each cycle; the datapath holds the cursor,
    // the screen store and the result register that decouples the two channels, so a
    // new command is taken while a finished result still waits for its transaction.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_cmd.ready = in_ready;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    tcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_fill_color (r_fill_color),
        .i_in         (i_cmd),
        .o_out        (o_rsp)
    );
endmodule

// ----- design/tcw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/tcw_ctrl.sv -----
// Controller state machine that sequences commands, sweeps and results.
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd o_cmd
);
    import tcw_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.mem_op = MEM_NONE;
        cmd.cur_op = CUR_NONE;
        case (r_state)
            S_INIT: begin
                cmd.mem_op  = MEM_INIT;
                cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.action)
                    ACT_PUT: begin
                        n_state = S_DONE;
                        if (!i_sts.is_newline) begin
                            cmd.mem_op = MEM_PUT;
                        end
                        if (i_sts.is_newline || i_sts.col_last) begin
                            cmd.cur_op = CUR_NEWLINE;
                            if (i_sts.row_last) begin
                                cmd.set_scrolled = 1'b1;
                                cmd.cnt_clear    = 1'b1;
                                n_state          = S_SCROLL;
                            end
                        end else begin
                            cmd.cur_op = CUR_ADV;
                        end
                    end
                    ACT_CLEAR: begin
                        cmd.cur_op    = CUR_HOME;
                        cmd.cnt_clear = 1'b1;
                        n_state       = S_CLEAR;
                    end
                    ACT_READ: begin
                        cmd.mem_op = MEM_READ;
                        n_state    = S_RWAIT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RWAIT: begin
                cmd.capture = 1'b1;
                n_state     = S_DONE;
            end
            S_SCROLL: begin
                cmd.mem_op  = MEM_COPY;
                cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FILL;
            end
            S_FILL, S_CLEAR: begin
                cmd.mem_op  = MEM_FILL;
                cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    a_load_goes_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_item |=> r_state == S_EXEC)
        else $error("accepted command did not enter execution");

    a_load_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over an untaken result");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && n_state == S_SCROLL) |-> i_sts.row_last)
        else $error("scroll started away from the last row");
endmodule

// ----- design/tcw_dp.sv -----
// Datapath: cursor, command latch, sweep counter, screen store and result register.
module tcw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_sts              o_sts,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_fill_color,
    tcw_in_if.sink                        i_in,
    tcw_out_if.source                     o_out
);
    import tcw_pkg::*;

    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ACTION_W-1:0] r_act;
    logic [CHAR_W-1:0]   r_char;
    logic [COLOR_W-1:0]  r_color;
    logic [COL_W-1:0]    r_rcol;
    logic [ROW_W-1:0]    r_rrow;
    logic [ADDR_W-1:0]   r_cnt;
    logic                r_scrolled;
    logic [CELL_W-1:0]   r_rd_data;
    logic                r_cp_pend;
    logic [ADDR_W-1:0]   r_cp_addr;

    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_data;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic                r_out_scrolled;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [CELL_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [CELL_W-1:0]   rdata;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   copy_src;
    logic                in_range;
    logic                row_last;

    assign cur_addr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS)) + ADDR_W'(r_col);
    assign rd_addr  = ADDR_W'(ADDR_W'(r_rrow) * ADDR_W'(COLUMNS)) + ADDR_W'(r_rcol);
    assign copy_src = ADDR_W'({1'b0, r_cnt} + (ADDR_W + 1)'(COLUMNS));
    assign in_range = (int'(r_rcol) < COLUMNS) && (int'(r_rrow) < ROWS);
    assign row_last = (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = BLANK_RESET;
        raddr = rd_addr;
        case (i_cmd.mem_op)
            MEM_PUT: begin
                we    = 1'b1;
                waddr = cur_addr;
                wdata = {r_color, r_char};
            end
            MEM_INIT: begin
                we = 1'b1;
            end
            MEM_FILL: begin
                we    = 1'b1;
                wdata = {i_fill_color, BLANK_CODE};
            end
            MEM_COPY: begin
                raddr = copy_src;
            end
            MEM_READ: begin
                raddr = rd_addr;
            end
            default: begin
                we = 1'b0;
            end
        endcase
        // The second half of a row copy: read data lands in the cycle after its read.
        if (r_cp_pend) begin
            we    = 1'b1;
            waddr = r_cp_addr;
            wdata = rdata;
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_scrolled  <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clear) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end

            case (i_cmd.cur_op)
                CUR_HOME: begin
                    r_row <= '0;
                    r_col <= '0;
                end
                CUR_ADV: begin
                    r_col <= r_col + 1'b1;
                end
                CUR_NEWLINE: begin
                    r_col <= '0;
                    if (!row_last) begin
                        r_row <= r_row + 1'b1;
                    end
                end
                default: begin
                    r_col <= r_col;
                end
            endcase

            if (i_cmd.load_item) begin
                r_scrolled <= 1'b0;
            end else if (i_cmd.set_scrolled) begin
                r_scrolled <= 1'b1;
            end

            r_cp_pend <= (i_cmd.mem_op == MEM_COPY);

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_cnt;
        if (i_cmd.load_item) begin
            r_act   <= i_in.action;
            r_char  <= i_in.char_code;
            r_color <= i_in.cell_color;
            r_rcol  <= i_in.read_col;
            r_rrow  <= i_in.read_row;
        end
        if (i_cmd.capture) begin
            r_rd_data <= in_range ? rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out_data     <= (r_act == ACT_READ) ? r_rd_data : '0;
            r_out_row      <= r_row;
            r_out_col      <= r_col;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_sts.action        = r_act;
    assign o_sts.is_newline    = (r_char == NEWLINE_CODE);
    assign o_sts.col_last      = (r_col == COL_W'(COLUMNS - 1));
    assign o_sts.row_last      = row_last;
    assign o_sts.cnt_copy_last = (r_cnt == ADDR_W'(COPY_LAST));
    assign o_sts.cnt_last      = (r_cnt == ADDR_W'(CELLS - 1));
    assign o_sts.out_busy      = r_out_valid && !o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_data  = r_out_data;
    assign o_out.cursor_row = r_out_row;
    assign o_out.cursor_col = r_out_col;
    assign o_out.scrolled   = r_out_scrolled;

    a_cursor_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < COLUMNS)
        else $error("cursor column left the screen");

    a_cursor_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < ROWS)
        else $error("cursor row left the screen");

    a_copy_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> (i_cmd.mem_op == MEM_NONE || i_cmd.mem_op == MEM_COPY))
        else $error("copy write collides with another store write");
endmodule

// ----- tb/tb_text_console_writer_top.sv -----
// Self-checking testbench for the text console writer: random commands against a screen model.
module tb_text_console_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Action code 3 has no name in the package; the block must ignore it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_WAIT      = 12;
    // A scroll or a clear sweeps the whole store, and the reset pass does too, so
    // the watchdog allows many such sweeps back to back before it gives up.
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 250;
    localparam int PHASES        = 5;

    localparam logic [PADDR_W-1:0] FILL_COLOR_ADDR = {REG_FILL_COLOR, 2'b00};

    // One command as the sender sees it, with the idle time it waits before it
    // and whether it must hold off until every outstanding result has come back.
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_code;
        logic [COLOR_W-1:0]  cell_color;
        logic [COL_W-1:0]    read_col;
        logic [ROW_W-1:0]    read_row;
        int unsigned         gap;
        bit                  drain_first;
    } t_console_cmd;

    typedef struct {
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } t_console_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tcw_in_if  cmd_if ();
    tcw_out_if rsp_if ();

    text_console_writer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Screen model. It mirrors the store, the cursor and the fill color,
    // and is advanced once for every command transaction, in order.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  screen_model [CELLS];
    int                 model_row;
    int                 model_col;
    logic [COLOR_W-1:0] model_fill;

    t_console_cmd cmd_pending [$];
    t_console_rsp rsp_expect [$];
    int unsigned  cmds_sent;
    int unsigned  cmds_accepted;
    int unsigned  err_count;
    bit           calm_seq;

    function automatic void model_blank_all();
        for (int i = 0; i < CELLS; i++) begin
            screen_model[i] = {model_fill, BLANK_CODE};
        end
    endfunction

    // Moves the cursor to the start of the next row. Leaving the bottom row
    // shifts every row up by one and blanks the bottom row in the fill color.
    function automatic bit model_next_line();
        model_col = 0;
        if (model_row + 1 >= ROWS) begin
            model_row = ROWS - 1;
            for (int i = 0; i <= COPY_LAST; i++) begin
                screen_model[i] = screen_model[i + COLUMNS];
            end
            for (int i = COPY_LAST + 1; i < CELLS; i++) begin
                screen_model[i] = {model_fill, BLANK_CODE};
            end
            return 1'b1;
        end
        model_row++;
        return 1'b0;
    endfunction

    function automatic t_console_rsp console_step(t_console_cmd c);
        t_console_rsp r;
        r.cell_data = '0;
        r.scrolled  = 1'b0;
        case (c.action)
            ACT_PUT: begin
                // A newline writes nothing; it only moves the cursor.
                if (c.char_code == NEWLINE_CODE) begin
                    r.scrolled = model_next_line();
                end else begin
                    screen_model[model_row * COLUMNS + model_col] = {c.cell_color, c.char_code};
                    model_col++;
                    if (model_col >= COLUMNS) begin
                        r.scrolled = model_next_line();
                    end
                end
            end
            ACT_CLEAR: begin
                model_blank_all();
                model_row = 0;
                model_col = 0;
            end
            ACT_READ: begin
                // Coordinates off the screen read as zero.
                if (c.read_col < COLUMNS && c.read_row < ROWS) begin
                    r.cell_data = screen_model[c.read_row * COLUMNS + c.read_col];
                end
            end
            default: begin
                // The unused action changes nothing and reports the cursor as it is.
            end
        endcase
        r.cursor_row = ROW_W'(model_row);
        r.cursor_col = COL_W'(model_col);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command driver. It takes the next command from the pending queue,
    // waits out its idle gap, optionally waits for all results to return,
    // then holds valid until the transaction completes. The model is
    // stepped at the edge where the transaction is accepted.
    // ------------------------------------------------------------------
    t_console_cmd cmd_next;
    t_console_cmd cmd_on_bus;
    bit           cmd_held;
    int unsigned  gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_held = 1'b0;
            gap_left = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                rsp_expect.push_back(console_step(cmd_on_bus));
                cmds_accepted++;
            end
            // Nothing may change while a command waits on ready.
            if (!(cmd_if.valid && !cmd_if.ready)) begin
                if (!cmd_held && cmd_pending.size() != 0) begin
                    cmd_next = cmd_pending.pop_front();
                    cmd_held = 1'b1;
                    gap_left = cmd_next.gap;
                end
                if (cmd_held && gap_left != 0) begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_held && !(cmd_next.drain_first && rsp_expect.size() != 0)) begin
                    cmd_if.valid      <= 1'b1;
                    cmd_if.action     <= cmd_next.action;
                    cmd_if.char_code  <= cmd_next.char_code;
                    cmd_if.cell_color <= cmd_next.cell_color;
                    cmd_if.read_col   <= cmd_next.read_col;
                    cmd_if.read_row   <= cmd_next.read_row;
                    cmd_on_bus = cmd_next;
                    cmd_held   = 1'b0;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Each result transaction is compared field by field
    // with the oldest expectation. Ready is withheld for a random number
    // of cycles per result, with occasional stretches of no stalling.
    // ------------------------------------------------------------------
    int unsigned  rsp_stall;
    int unsigned  rsp_calm_left;
    t_console_rsp rsp_want;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall     = 0;
            rsp_calm_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_expect.size() == 0) begin
                    $display({"%0t ns: unexpected result, expected none, ",
                              "actual data 0x%0h row %0d col %0d scrolled %0b"},
                             $time, rsp_if.cell_data, rsp_if.cursor_row, rsp_if.cursor_col,
                             rsp_if.scrolled);
                    err_count++;
                end else begin
                    rsp_want = rsp_expect.pop_front();
                    check_field("cell_data", rsp_want.cell_data, rsp_if.cell_data);
                    check_field("cursor_row", rsp_want.cursor_row, rsp_if.cursor_row);
                    check_field("cursor_col", rsp_want.cursor_col, rsp_if.cursor_col);
                    check_field("scrolled", rsp_want.scrolled, rsp_if.scrolled);
                end
                if (rsp_calm_left != 0) begin
                    rsp_calm_left--;
                    rsp_stall = 0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rsp_calm_left = $urandom_range(10, 40);
                    rsp_stall     = 0;
                end else begin
                    rsp_stall = $urandom_range(0, MAX_WAIT);
                end
            end else if (rsp_stall != 0 && rsp_if.valid) begin
                rsp_stall--;
            end
            rsp_if.ready <= (rsp_stall == 0);
        end
    end

    // The watchdog ends a run that stops making progress on either channel.
    int unsigned idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] color, input logic [COL_W-1:0] rcol,
                             input logic [ROW_W-1:0] rrow, input bit drain);
        t_console_cmd c;
        c.action      = act;
        c.char_code   = ch;
        c.cell_color  = color;
        c.read_col    = rcol;
        c.read_row    = rrow;
        c.gap         = calm_seq ? 0 : $urandom_range(0, MAX_WAIT);
        c.drain_first = drain || ($urandom_range(0, 49) == 0);
        cmd_pending.push_back(c);
        cmds_sent++;
    endtask

    // Returns once every queued command has been accepted and answered.
    task automatic wait_drained();
        while (cmds_accepted != cmds_sent || rsp_expect.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the fill color over the register port, then reads it back.
    task automatic program_fill_color(input logic [COLOR_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FILL_COLOR_ADDR;
        pwdata  <= {{(APB_DATA_W - COLOR_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_fill = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[COLOR_W-1:0] !== value) begin
            $display("%0t ns: fill_color read-back mismatch, expected 0x%0h, actual 0x%0h",
                     $time, value, prdata[COLOR_W-1:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [COLOR_W-1:0] fill_value;
        logic [COLOR_W-1:0] run_color;
        logic [COLOR_W-1:0] put_color;
        logic [CHAR_W-1:0]  ch;
        logic [COL_W-1:0]   rcol;
        logic [ROW_W-1:0]   rrow;
        logic [ACTION_W-1:0] act;
        int unsigned        phase_items;
        int unsigned        pick;
        int unsigned        len;
        bit                 fixed_color;

        // Every input is known from time zero, while reset is held low.
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.action     = ACT_PUT;
        cmd_if.char_code  = '0;
        cmd_if.cell_color = '0;
        cmd_if.read_col   = '0;
        cmd_if.read_row   = '0;
        rsp_if.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmds_sent         = 0;
        cmds_accepted     = 0;
        err_count         = 0;
        calm_seq          = 1'b0;

        model_fill = FILL_COLOR_RESET;
        model_row  = 0;
        model_col  = 0;
        model_blank_all();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The store must come out of reset blank in the reset
        // color; the block takes no command until its clearing pass is over,
        // and the driver simply waits on ready through it.
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        queue_cmd(ACT_READ, 8'hFF, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1), 1'b0);
        // Extreme character and color bytes, a blank, then a plain newline.
        queue_cmd(ACT_PUT, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        queue_cmd(ACT_PUT, 8'hFF, 8'hFF, 7'h7F, 5'h1F, 1'b0);
        queue_cmd(ACT_PUT, BLANK_CODE, 8'h5A, 7'd0, 5'd0, 1'b0);
        queue_cmd(ACT_PUT, NEWLINE_CODE, 8'hA5, 7'd3, 5'd3, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd2, 5'd0, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd3, 5'd0, 1'b0);
        // Reads off the screen return zero.
        queue_cmd(ACT_READ, 8'h00, 8'h00, COL_W'(COLUMNS), 5'd0, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'h7F, 5'h1F, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd0, ROW_W'(ROWS), 1'b0);
        // The unused action with every field bit set must be ignored.
        queue_cmd(ACT_UNUSED, 8'hFF, 8'hFF, 7'h7F, 5'h1F, 1'b0);
        queue_cmd(ACT_PUT, 8'h41, 8'h1E, 7'd0, 5'd0, 1'b0);
        // Clear after the sender has waited for every result to come back.
        queue_cmd(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd1, 1'b1);
        queue_cmd(ACT_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0, 1'b0);
        queue_cmd(ACT_PUT, 8'h7E, 8'h81, 7'd0, 5'd0, 1'b0);

        // Random part, in phases with a different fill color each. Most
        // traffic is runs of text, which drive the cursor across line ends
        // and into scrolling; reads sample the store, with a bias towards the
        // bottom row where the cursor spends most of its time.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (phase)
                0: fill_value = 8'h00;
                1: fill_value = 8'hFF;
                2: fill_value = FILL_COLOR_RESET;
                default: fill_value = COLOR_W'($urandom_range(0, 255));
            endcase
            program_fill_color(fill_value);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                calm_seq = ($urandom_range(0, 4) == 0);
                pick     = $urandom_range(0, 99);
                if (pick < 50) begin
                    // A run of text with an occasional newline.
                    len         = $urandom_range(1, 90);
                    run_color   = COLOR_W'($urandom_range(0, 255));
                    fixed_color = 1'($urandom_range(0, 1));
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 15) == 0) begin
                            ch = NEWLINE_CODE;
                        end else begin
                            ch = CHAR_W'($urandom_range(0, 255));
                        end
                        put_color = fixed_color ? run_color : COLOR_W'($urandom_range(0, 255));
                        queue_cmd(ACT_PUT, ch, put_color, COL_W'($urandom), ROW_W'($urandom),
                                  1'b0);
                    end
                    phase_items += len;
                end else if (pick < 75) begin
                    len = $urandom_range(1, 8);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 6) == 0) begin
                            rcol = COL_W'($urandom_range(0, (1 << COL_W) - 1));
                            rrow = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
                        end else begin
                            rcol = COL_W'($urandom_range(0, COLUMNS - 1));
                            rrow = $urandom_range(0, 2) == 0 ? ROW_W'(ROWS - 1)
                                                             : ROW_W'($urandom_range(0, ROWS - 1));
                        end
                        queue_cmd(ACT_READ, CHAR_W'($urandom), COLOR_W'($urandom), rcol, rrow,
                                  1'b0);
                    end
                    phase_items += len;
                end else if (pick < 85) begin
                    // A few newlines in a row, which scroll once the cursor
                    // has reached the bottom row.
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        queue_cmd(ACT_PUT, NEWLINE_CODE, COLOR_W'($urandom), COL_W'($urandom),
                                  ROW_W'($urandom), 1'b0);
                    end
                    phase_items += len;
                end else if (pick < 87) begin
                    queue_cmd(ACT_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'($urandom),
                              ROW_W'($urandom), 1'b0);
                    phase_items++;
                end else begin
                    // Noise: any cheap action with every field random.
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(0, 2))
                            0: act = ACT_PUT;
                            1: act = ACT_READ;
                            default: act = ACT_UNUSED;
                        endcase
                        queue_cmd(act, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'($urandom),
                                  ROW_W'($urandom), 1'b0);
                        if (act != ACT_UNUSED) begin
                            phase_items++;
                        end
                    end
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && rsp_expect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
